// ----- sv/rgse_pkg.sv -----
// Shared types, constants and the gray conversion for the RGB gray Sobel edge filter.
// Depends on nothing; rgse_window and the core refer to it by scoped names.
package rgse_pkg;

   // Longest row the line store can hold.
   localparam int MaxWidth = 2048;
   localparam int AddrW    = $clog2(MaxWidth);
   // Holds the effective width plus one (the tail of a frame still owed).
   localparam int PendW    = $clog2(MaxWidth + 2);
   localparam int DimW     = 12;
   localparam int CmpW     = (PendW > DimW) ? PendW : DimW;
   localparam int MinDim   = 3;
   localparam int PixW     = 8;
   localparam int CsrIdxW  = 2;

   localparam logic [DimW-1:0] FrameWidthReset  = DimW'(640);
   localparam logic [DimW-1:0] FrameHeightReset = DimW'(480);

   localparam logic [CsrIdxW-1:0] CsrFrameWidth  = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CsrFrameHeight = CsrIdxW'(1);

   // Luma weights in 0.16 fixed point.
   localparam logic [15:0] GrayRedCoef   = 16'd13933;
   localparam logic [15:0] GrayGreenCoef = 16'd46872;
   localparam logic [15:0] GrayBlueCoef  = 16'd4732;

   localparam logic [PixW-1:0] PixMax = PixW'(255);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef struct packed {
      logic [PixW-1:0] top;
      logic [PixW-1:0] mid;
      logic [PixW-1:0] bot;
   } win_col_type;

   typedef struct packed {
      logic        shift;
      win_col_type col;
   } win_ctl_type;

   // Each product is truncated on its own before the sum; the sum never exceeds 254.
   function automatic logic [PixW-1:0] to_gray(input logic [PixW-1:0] r,
                                               input logic [PixW-1:0] g,
                                               input logic [PixW-1:0] b);
      logic [23:0] pr;
      logic [23:0] pg;
      logic [23:0] pb;
      logic [9:0]  sum;
      pr  = 24'(r) * 24'(GrayRedCoef);
      pg  = 24'(g) * 24'(GrayGreenCoef);
      pb  = 24'(b) * 24'(GrayBlueCoef);
      sum = 10'(pr[23:16]) + 10'(pg[23:16]) + 10'(pb[23:16]);
      return sum[PixW-1:0];
   endfunction

endpackage

// ----- sv/rgse_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; a read of the address being written returns the old content.
module rgse_ram #(
   parameter int Width = 16,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rgse_window.sv -----
// 3x3 gray window and the Sobel L1 magnitude of its current contents.
// Depends on rgse_pkg for the column struct and pixel width.
module rgse_window (
   input  logic                    clock,
   input  logic                    reset,
   input  rgse_pkg::win_ctl_type   win_ctl,
   output logic [rgse_pkg::PixW-1:0] center,
   output logic [rgse_pkg::PixW-1:0] magnitude
);

   logic [rgse_pkg::PixW-1:0] win_ff [9];
   logic [rgse_pkg::PixW-1:0] win_in [9];
   logic [9:0]  gx_pos;
   logic [9:0]  gx_neg;
   logic [9:0]  gy_pos;
   logic [9:0]  gy_neg;
   logic [9:0]  gx_abs;
   logic [9:0]  gy_abs;
   logic [10:0] mag_sum;

   // Rows shift one column left; the new right column is the line store word and the gray pixel.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i*3]     = win_ff[i*3 + 1];
         win_in[i*3 + 1] = win_ff[i*3 + 2];
      end
      win_in[2] = win_ctl.col.top;
      win_in[5] = win_ctl.col.mid;
      win_in[8] = win_ctl.col.bot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (win_ctl.shift) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_comb begin
      gx_pos  = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(win_ff[8]);
      gx_neg  = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(win_ff[6]);
      gy_pos  = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
      gy_neg  = 10'(win_ff[6]) + {1'b0, win_ff[7], 1'b0} + 10'(win_ff[8]);
      gx_abs  = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
      gy_abs  = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
      mag_sum = 11'(gx_abs) + 11'(gy_abs);
      if (mag_sum > 11'(rgse_pkg::PixMax)) begin
         magnitude = rgse_pkg::PixMax;
      end else begin
         magnitude = mag_sum[rgse_pkg::PixW-1:0];
      end
   end

   assign center = win_ff[4];

endmodule

// ----- sv/rgb_gray_sobel_edge_filter_core.sv -----
// RGB to gray conversion with a 3x3 Sobel edge magnitude on a raster pixel stream.
// Top level; uses rgse_pkg, rgse_ram (line store) and rgse_window (window and Sobel).
//
// Usage: pixels enter in raster order on the req_ channel (tuser = 0, tdata = red, green,
// blue); after the last pixel of a frame, flush beats (tuser = 1) drain the last row plus
// one pixel. Each result on rsp_ belongs to the pixel one row plus one pixel earlier in
// the stream. Border pixels carry their gray value with tuser set, interior pixels the
// saturated |Gx|+|Gy|. tlast marks the final flush result of a frame. A flush with nothing
// owed is accepted and produces no result.
// The csr_ channel writes frame_width (index 0) and frame_height (index 1); it is always
// ready and should only be used while the stream is idle.
// Throughput is one beat per cycle unless the receiver stalls. A beat passes three
// register stages: the line store read, the window update with the store write-back, and
// the output register. Both line stores share one RAM word per column; a read of the
// column written in the same cycle is forwarded.
// When the receiver stalls, the pipeline keeps taking beats until a result would have to
// enter the full output register; then req_tready drops until rsp_tready returns.
// Reset restores 640x480, clears the window and all counters; the line store is not
// cleared and needs no clearing pass.
module rgb_gray_sobel_edge_filter_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic                         req_tuser,   // operation
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // edge_value
   output logic                         rsp_tuser,   // is_border
   output logic                         rsp_tlast,   // end_of_frame
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rgse_pkg::CsrIdxW-1:0] csr_index,
   input  logic [rgse_pkg::DimW-1:0]    csr_data
);

   localparam int AddrW = rgse_pkg::AddrW;
   localparam int PendW = rgse_pkg::PendW;
   localparam int CmpW  = rgse_pkg::CmpW;
   localparam int DimW  = rgse_pkg::DimW;
   localparam int PixW  = rgse_pkg::PixW;

   // Configuration.
   logic [DimW-1:0] frame_width_ff;
   logic [DimW-1:0] frame_height_ff;

   // Position and owed results.
   logic [AddrW-1:0] column_ff;
   logic [AddrW-1:0] column_in;
   logic [DimW-1:0]  row_ff;
   logic [DimW-1:0]  row_in;
   logic [PendW-1:0] pending_ff;
   logic [PendW-1:0] pending_in;

   // Stage 1: line store read in flight.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_flush_ff, s1_flush_in;
   logic             s1_emit_ff, s1_emit_in;
   logic             s1_border_ff, s1_border_in;
   logic             s1_last_ff, s1_last_in;
   logic             s1_upper_ff, s1_upper_in;
   logic [PixW-1:0]  s1_gray_ff, s1_gray_in;
   logic [AddrW-1:0] s1_addr_ff;
   logic             fwd_ff, fwd_in;
   logic [15:0]      fwd_data_ff;

   // Stage 2: window holds the pixel, magnitude under way.
   logic             s2_valid_ff;
   logic             s2_flush_ff;
   logic             s2_border_ff;
   logic             s2_last_ff;
   logic [PixW-1:0]  s2_value_ff, s2_value_in;

   // Output register.
   logic             out_valid_ff, out_valid_in;
   logic [PixW-1:0]  out_data_ff, out_data_in;
   logic             out_border_ff;
   logic             out_last_ff;

   logic                  advance;
   logic                  accept;
   logic                  is_flush;
   logic [CmpW-1:0]       width_ext;
   logic [PendW-1:0]      eff_w;
   logic [DimW-1:0]       eff_h;
   logic [DimW:0]         row_ext;
   logic [DimW:0]         h_ext;
   logic                  col_nz;
   logic                  last_col;
   logic                  last_row;
   logic [PendW-1:0]      owed;
   logic [PendW-1:0]      drained;
   logic [AddrW-1:0]      rd_addr;
   logic                  wr_en;
   logic [15:0]           wr_data;
   logic [15:0]           ram_q;
   logic [15:0]           rd_word;
   rgse_pkg::win_ctl_type win_ctl;
   logic [PixW-1:0]       win_center;
   logic [PixW-1:0]       win_magnitude;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= rgse_pkg::FrameWidthReset;
         frame_height_ff <= rgse_pkg::FrameHeightReset;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rgse_pkg::CsrFrameWidth) begin
            frame_width_ff <= csr_data;
         end
         if (csr_index == rgse_pkg::CsrFrameHeight) begin
            frame_height_ff <= csr_data;
         end
      end
   end

   // Effective frame size.
   always_comb begin
      width_ext = CmpW'(frame_width_ff);
      if (width_ext < CmpW'(rgse_pkg::MinDim)) begin
         width_ext = CmpW'(rgse_pkg::MinDim);
      end else if (width_ext > CmpW'(rgse_pkg::MaxWidth)) begin
         width_ext = CmpW'(rgse_pkg::MaxWidth);
      end
      eff_w = width_ext[PendW-1:0];
      eff_h = (frame_height_ff < DimW'(rgse_pkg::MinDim)) ? DimW'(rgse_pkg::MinDim)
                                                          : frame_height_ff;
   end

   // The pipeline only waits when a result would land in a full output register.
   assign advance    = !(s2_valid_ff && out_valid_ff && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;
   assign is_flush   = (rgse_pkg::op_type'(req_tuser) == rgse_pkg::OP_FLUSH);

   // Stage 0: address, position flags and gray value of the incoming beat.
   always_comb begin
      row_ext   = {1'b0, row_ff};
      h_ext     = {1'b0, eff_h};
      col_nz    = (column_ff != '0);
      last_col  = (PendW'(column_ff) + PendW'(1) >= eff_w);
      last_row  = (row_ext + (DimW+1)'(1) >= h_ext);
      owed      = (pending_ff > eff_w + PendW'(1)) ? (eff_w + PendW'(1)) : pending_ff;
      drained   = eff_w + PendW'(1) - owed;

      column_in    = column_ff;
      row_in       = row_ff;
      pending_in   = pending_ff;
      s1_valid_in  = 1'b0;
      s1_flush_in  = is_flush;
      s1_emit_in   = 1'b0;
      s1_border_in = 1'b1;
      s1_last_in   = 1'b0;
      s1_upper_in  = 1'b0;
      s1_gray_in   = rgse_pkg::to_gray(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
      rd_addr      = (PendW'(column_ff) < eff_w) ? column_ff : AddrW'(eff_w - PendW'(1));

      if (is_flush) begin
         s1_emit_in  = 1'b1;
         s1_last_in  = (owed == PendW'(1));
         s1_upper_in = (drained == '0);
         rd_addr     = (drained == '0) ? AddrW'(eff_w - PendW'(1))
                                       : AddrW'(drained - PendW'(1));
         if (accept && (pending_ff != '0)) begin
            s1_valid_in = 1'b1;
            pending_in  = owed - PendW'(1);
         end
      end else begin
         s1_emit_in   = (row_ff >= DimW'(2)) || ((row_ff == DimW'(1)) && col_nz);
         // The first column of a row outputs the last column of the row two above.
         s1_border_in = !col_nz || (row_ff == DimW'(1)) || (row_ff >= eff_h) ||
                        (column_ff == AddrW'(1)) || (PendW'(column_ff) >= eff_w);
         if (accept) begin
            s1_valid_in = 1'b1;
            pending_in  = '0;
            if (last_col) begin
               column_in = '0;
               if (last_row) begin
                  row_in     = '0;
                  pending_in = eff_w + PendW'(1);
               end else begin
                  row_in = row_ff + DimW'(1);
               end
            end else begin
               column_in = column_ff + AddrW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         row_ff     <= '0;
         pending_ff <= '0;
      end else begin
         column_ff  <= column_in;
         row_ff     <= row_in;
         pending_ff <= pending_in;
      end
   end

   // Stage 1: read-modify-write of the line store word {upper, middle}.
   assign wr_en   = advance && s1_valid_ff && !s1_flush_ff;
   assign rd_word = fwd_ff ? fwd_data_ff : ram_q;
   assign wr_data = {rd_word[7:0], s1_gray_ff};
   assign fwd_in  = wr_en && (rd_addr == s1_addr_ff);

   rgse_ram #(
      .Width (16),
      .Depth (rgse_pkg::MaxWidth)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flush_ff  <= s1_flush_in;
         s1_emit_ff   <= s1_emit_in;
         s1_border_ff <= s1_border_in;
         s1_last_ff   <= s1_last_in;
         s1_upper_ff  <= s1_upper_in;
         s1_gray_ff   <= s1_gray_in;
         s1_addr_ff   <= rd_addr;
         fwd_data_ff  <= wr_data;
      end
   end

   assign win_ctl.shift   = wr_en;
   assign win_ctl.col.top = rd_word[15:8];
   assign win_ctl.col.mid = rd_word[7:0];
   assign win_ctl.col.bot = s1_gray_ff;

   rgse_window u_window (
      .clock     (clock),
      .reset     (reset),
      .win_ctl   (win_ctl),
      .center    (win_center),
      .magnitude (win_magnitude)
   );

   assign s2_value_in = s1_upper_ff ? rd_word[15:8] : rd_word[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_flush_ff  <= s1_flush_ff;
         s2_border_ff <= s1_border_ff || s1_flush_ff;
         s2_last_ff   <= s1_last_ff && s1_flush_ff;
         s2_value_ff  <= s2_value_in;
      end
   end

   // Output register.
   always_comb begin
      if (s2_flush_ff) begin
         out_data_in = s2_value_ff;
      end else if (s2_border_ff) begin
         out_data_in = win_center;
      end else begin
         out_data_in = win_magnitude;
      end
      priority if (advance && s2_valid_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         out_data_ff   <= out_data_in;
         out_border_ff <= s2_border_ff;
         out_last_ff   <= s2_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_border_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // Results are owed only right after a frame ended, when the position is back at the origin.
   a_pending_at_origin: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != '0) |-> ((column_ff == '0) && (row_ff == '0)))
      else $error("pending results while the position is not at the frame origin");

   // The frame's end is only ever marked on a flush result, and those are all border pixels.
   a_last_is_border: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("end of frame on a result that is not a border pixel");

   // A freshly loaded forward flag must come from a write at the read's own edge.
   a_fwd_has_write: assert property (@(posedge clock) disable iff (reset)
      (fwd_ff && $past(advance)) |-> ($past(wr_en) && ($past(s1_addr_ff) == s1_addr_ff)))
      else $error("line store forward without a matching write");

   // A stall of the input side, which only ever comes with a result waiting in stage two, holds stage two.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(s2_valid_ff) && $stable(s1_addr_ff))
      else $error("pipeline moved while the input side was stalled");
`endif

endmodule
